// ===== rtl/lexkw_pkg.sv =====
// Package for the keyword lexer: token kinds, character codes, result word layout
// and the reserved-word table with its match function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lexkw_pkg;

  localparam int MAX_IDENT_LEN_DEF = 15;
  localparam int NUMBER_WIDTH_DEF  = 32;
  localparam int OFFSET_WIDTH_DEF  = 24;

  localparam int KIND_W  = 5;
  localparam int LINE_W  = 16;
  localparam int VALUE_W = 32;
  localparam int FIELD_W = 24;

  localparam logic [KIND_W-1:0] KIND_ERROR      = 5'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT      = 5'd1;
  localparam logic [KIND_W-1:0] KIND_NUMBER     = 5'd2;
  localparam logic [KIND_W-1:0] KIND_COMMENT    = 5'd3;
  localparam logic [KIND_W-1:0] KIND_FIRST_WORD = 5'd4;
  localparam logic [KIND_W-1:0] KIND_END        = 5'd23;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int NUM_WORDS = 19;
  localparam int KW_CHARS  = 7;
  localparam int TEXT_W    = 8 * KW_CHARS;

  // last character of each word sits in the lowest byte
  localparam logic [TEXT_W-1:0] KW_TEXT [NUM_WORDS] = '{
    TEXT_W'("and"), TEXT_W'("begin"), TEXT_W'("boolean"), TEXT_W'("elif"),
    TEXT_W'("else"), TEXT_W'("end"), TEXT_W'("false"), TEXT_W'("for"),
    TEXT_W'("if"), TEXT_W'("integer"), TEXT_W'("not"), TEXT_W'("of"),
    TEXT_W'("or"), TEXT_W'("program"), TEXT_W'("read"), TEXT_W'("set"),
    TEXT_W'("to"), TEXT_W'("true"), TEXT_W'("write")
  };

  localparam logic [3:0] KW_LEN [NUM_WORDS] = '{
    4'd3, 4'd5, 4'd7, 4'd4, 4'd4, 4'd3, 4'd5, 4'd3, 4'd2, 4'd7,
    4'd3, 4'd2, 4'd2, 4'd7, 4'd4, 4'd3, 4'd2, 4'd4, 4'd5
  };

  localparam int RES_DEPTH = 4;
  localparam int RES_PW    = $clog2(RES_DEPTH);
  localparam int RES_CW    = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LINE_W-1:0]  line;
    logic [VALUE_W-1:0] value;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic [KIND_W-1:0] keyword_kind(
    input logic [KW_CHARS-1:0][7:0] chars,
    input logic [3:0]               len
  );
    logic [KIND_W-1:0] kind;
    logic              hit;
    kind = KIND_IDENT;
    for (int w = 0; w < NUM_WORDS; w++) begin
      hit = (KW_LEN[w] == len);
      for (int i = 0; i < KW_CHARS; i++) begin
        if (i < int'(KW_LEN[w])) begin
          if (KW_TEXT[w][8*(int'(KW_LEN[w]) - 1 - i) +: 8] != chars[i]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        kind = KIND_FIRST_WORD + KIND_W'(w);
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/keyword_lexer_byte_stream_top.sv =====
// Keyword lexer top level: one source byte per word in, one token per word out.
// Each accepted byte is held in the input register, then its token words go to the result queue.
// Throughput: one byte per cycle while the queue has room; a byte that gives two tokens puts
// two words into the four-word result queue, whose room sets the input stall point.
// Reset: rst (synchronous) sets line count to 1, offset to 0, clears halt and the queue.
// Depends on lexkw_pkg, lexkw_scan and lexkw_res_fifo.
`timescale 1ns / 1ps
`default_nettype none

module keyword_lexer_byte_stream_top #(
  parameter int MAX_IDENT_LEN = lexkw_pkg::MAX_IDENT_LEN_DEF,
  parameter int NUMBER_WIDTH  = lexkw_pkg::NUMBER_WIDTH_DEF,
  parameter int OFFSET_WIDTH  = lexkw_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // char_code
  input  wire logic        s_tuser,   // start_of_source
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // line_number, number_value, token_start, token_length
  output logic [4:0]       m_tuser,   // token_kind
  output logic             m_tlast    // last_in_run
);
  import lexkw_pkg::*;

  push_t             push;
  res_t              head;
  logic              room;
  logic [RES_CW-1:0] level;

  lexkw_scan #(
    .MAX_IDENT_LEN (MAX_IDENT_LEN),
    .NUMBER_WIDTH  (NUMBER_WIDTH),
    .OFFSET_WIDTH  (OFFSET_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_start (s_tuser),
    .in_char  (s_tdata),
    .room     (room),
    .push     (push)
  );

  lexkw_res_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head       (head),
    .head_valid (m_tvalid),
    .head_ready (m_tready),
    .level      (level)
  );

  assign m_tdata = {head.length, head.start, head.value, head.line};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= RES_CW'(RES_DEPTH))
    else $error("result queue overfilled");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> level <= RES_CW'(RES_DEPTH - 2))
    else $error("push without room");

  a_second_kind: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> (push.second.kind == KIND_END || push.second.kind == KIND_ERROR))
    else $error("second token of a byte is neither end nor error");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd3)
    else $error("more than two tokens from one byte");

endmodule

`default_nettype wire

// ===== rtl/lexkw_scan.sv =====
// Scanner core: input register, lexer state and the per-byte token logic.
// Depends on lexkw_pkg; hands zero, one or two result words to the result queue.
`timescale 1ns / 1ps
`default_nettype none

module lexkw_scan #(
  parameter int MAX_IDENT_LEN = lexkw_pkg::MAX_IDENT_LEN_DEF,
  parameter int NUMBER_WIDTH  = lexkw_pkg::NUMBER_WIDTH_DEF,
  parameter int OFFSET_WIDTH  = lexkw_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_start,
  input  wire logic [7:0]      in_char,
  input  wire logic            room,
  output lexkw_pkg::push_t     push
);
  import lexkw_pkg::*;

  localparam int LW = $clog2(MAX_IDENT_LEN + 1);
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_IDENT  = 4'd1;
  localparam logic [3:0] M_ZERO   = 4'd2;
  localparam logic [3:0] M_PREFIX = 4'd3;
  localparam logic [3:0] M_DIGITS = 4'd4;
  localparam logic [3:0] M_HASH   = 4'd5;
  localparam logic [3:0] M_BRACE  = 4'd6;
  localparam logic [3:0] M_BLOCK  = 4'd7;
  localparam logic [3:0] M_DASH   = 4'd8;

  function automatic logic [FIELD_W-1:0] cap_field(input logic [32:0] v);
    return (v > 33'(24'hFFFFFF)) ? '1 : v[FIELD_W-1:0];
  endfunction

  logic                      held;
  logic                      held_start;
  logic [7:0]                held_char;
  logic                      fire;
  logic                      step;

  logic [3:0]                mode;
  logic [LINE_W-1:0]         line_count;
  logic [OFFSET_WIDTH-1:0]   byte_offset;
  logic [OFFSET_WIDTH-1:0]   token_begin;
  logic [LW-1:0]             ident_len;
  logic [NUMBER_WIDTH-1:0]   number_accum;
  logic                      halted;
  logic [KW_CHARS-1:0][7:0]  ident_chars;

  logic [3:0]                mode_eff;
  logic [LINE_W-1:0]         line_eff;
  logic [LINE_W-1:0]         line_inc;
  logic [OFFSET_WIDTH-1:0]   cur;
  logic                      halt_eff;
  logic [7:0]                c;

  logic                      is_lower;
  logic                      is_upper;
  logic                      is_digit;
  logic                      is_bin;
  logic                      is_word;

  logic [3:0]                bt_mode;
  logic                      bt_line_up;
  logic                      bt_res;
  logic [KIND_W-1:0]         bt_kind;
  logic                      bt_ident;

  logic [3:0]                mode_next;
  logic                      line_up;
  logic                      a_valid;
  logic [KIND_W-1:0]         a_kind;
  logic                      a_plus1;
  logic                      a_line_new;
  logic                      a_number;
  logic                      b_valid;
  logic [KIND_W-1:0]         b_kind;
  logic                      use_bt;
  logic                      halt_set;
  logic                      append;
  logic                      accum_load;
  logic                      accum_shift;

  logic [31:0]               len32;
  logic [3:0]                kw_len;
  logic                      len_full;
  logic [OFFSET_WIDTH:0]     a_end;
  logic [OFFSET_WIDTH:0]     a_len;
  logic [63:0]               accum64;
  logic [LINE_W-1:0]         line_next;
  res_t                      res_a;
  res_t                      res_b;

  assign fire     = held && room;
  assign in_ready = !held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_start <= in_start;
      held_char  <= in_char;
    end
  end

  assign c        = held_char;
  assign mode_eff = held_start ? M_IDLE : mode;
  assign line_eff = held_start ? LINE_W'(1) : line_count;
  assign cur      = held_start ? '0 : byte_offset;
  assign halt_eff = held_start ? 1'b0 : halted;
  assign step     = fire && !halt_eff;
  assign line_inc = (line_eff == '1) ? line_eff : line_eff + LINE_W'(1);

  assign is_lower = (c >= CH_LA) && (c <= CH_LZ);
  assign is_upper = (c >= CH_UA) && (c <= CH_UZ);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_bin   = (c == CH_ZERO) || (c == CH_ONE);
  assign is_word  = is_lower || is_digit || (c == CH_UNDER);

  assign len32    = 32'(ident_len);
  assign len_full = len32 >= 32'(MAX_IDENT_LEN);
  assign kw_len   = (len32 > 32'(KW_CHARS)) ? 4'd0 : len32[3:0];

  // start of a new token
  always_comb begin
    bt_mode    = M_IDLE;
    bt_line_up = 1'b0;
    bt_res     = 1'b0;
    bt_kind    = KIND_ERROR;
    bt_ident   = 1'b0;
    priority if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
      bt_mode = M_IDLE;
    end else if (c == CH_LF) begin
      bt_line_up = 1'b1;
    end else if (is_lower) begin
      bt_mode  = M_IDENT;
      bt_ident = 1'b1;
    end else if (c == CH_HASH) begin
      bt_mode = M_HASH;
    end else if (c == CH_LBRACE) begin
      bt_mode = M_BRACE;
    end else if (c == CH_ZERO) begin
      bt_mode = M_ZERO;
    end else if (c == CH_NUL) begin
      bt_res  = 1'b1;
      bt_kind = KIND_END;
    end else begin
      bt_res = 1'b1;
    end
  end

  always_comb begin
    mode_next   = mode_eff;
    line_up     = 1'b0;
    a_valid     = 1'b0;
    a_kind      = KIND_ERROR;
    a_plus1     = 1'b0;
    a_line_new  = 1'b0;
    a_number    = 1'b0;
    b_valid     = 1'b0;
    b_kind      = KIND_END;
    use_bt      = 1'b0;
    halt_set    = 1'b0;
    append      = 1'b0;
    accum_load  = 1'b0;
    accum_shift = 1'b0;
    unique case (mode_eff)
      M_IDENT: begin
        if (is_word && !len_full) begin
          append = 1'b1;
        end else if (is_word || is_upper) begin
          a_valid   = 1'b1;
          halt_set  = 1'b1;
          mode_next = M_IDLE;
        end else begin
          a_valid = 1'b1;
          a_kind  = keyword_kind(ident_chars, kw_len);
          use_bt  = 1'b1;
        end
      end
      M_ZERO: begin
        if (c == CH_LB) begin
          mode_next = M_PREFIX;
        end else begin
          a_valid   = 1'b1;
          halt_set  = 1'b1;
          mode_next = M_IDLE;
        end
      end
      M_PREFIX: begin
        if (is_bin) begin
          accum_load = 1'b1;
          mode_next  = M_DIGITS;
        end else begin
          a_valid   = 1'b1;
          halt_set  = 1'b1;
          mode_next = M_IDLE;
        end
      end
      M_DIGITS: begin
        if (is_bin) begin
          accum_shift = 1'b1;
        end else begin
          a_valid  = 1'b1;
          a_kind   = KIND_NUMBER;
          a_number = 1'b1;
          use_bt   = 1'b1;
        end
      end
      M_HASH: begin
        if (c == CH_LF) begin
          line_up    = 1'b1;
          a_valid    = 1'b1;
          a_kind     = KIND_COMMENT;
          a_plus1    = 1'b1;
          a_line_new = 1'b1;
          mode_next  = M_IDLE;
        end else if (c == CH_NUL) begin
          a_valid   = 1'b1;
          a_kind    = KIND_COMMENT;
          b_valid   = 1'b1;
          halt_set  = 1'b1;
          mode_next = M_IDLE;
        end
      end
      M_BRACE: begin
        if (c == CH_DASH) begin
          mode_next = M_BLOCK;
        end else begin
          a_valid   = 1'b1;
          halt_set  = 1'b1;
          mode_next = M_IDLE;
        end
      end
      M_BLOCK, M_DASH: begin
        if (c == CH_NUL) begin
          a_valid   = 1'b1;
          a_kind    = KIND_COMMENT;
          b_valid   = 1'b1;
          halt_set  = 1'b1;
          mode_next = M_IDLE;
        end else if (c == CH_RBRACE && mode_eff == M_DASH) begin
          a_valid   = 1'b1;
          a_kind    = KIND_COMMENT;
          a_plus1   = 1'b1;
          mode_next = M_IDLE;
        end else if (c == CH_DASH) begin
          mode_next = M_DASH;
        end else begin
          line_up   = (c == CH_LF);
          mode_next = M_BLOCK;
        end
      end
      default: begin
        use_bt = 1'b1;
      end
    endcase
    if (use_bt) begin
      mode_next = bt_mode;
      line_up   = bt_line_up;
      b_valid   = bt_res;
      b_kind    = bt_kind;
      halt_set  = bt_res;
    end
  end

  assign line_next = line_up ? line_inc : line_eff;
  assign a_end     = {1'b0, cur} + (OFFSET_WIDTH + 1)'(a_plus1);
  assign a_len     = a_end - {1'b0, token_begin};
  assign accum64   = 64'(number_accum);

  always_comb begin
    res_a.kind   = a_kind;
    res_a.line   = a_line_new ? line_next : line_eff;
    res_a.value  = a_number ? accum64[VALUE_W-1:0] : '0;
    res_a.start  = cap_field(33'(token_begin));
    res_a.length = cap_field(33'(a_len));
    res_a.last   = !b_valid;
    res_b.kind   = b_kind;
    res_b.line   = line_eff;
    res_b.value  = '0;
    res_b.start  = cap_field(33'(cur));
    res_b.length = '0;
    res_b.last   = 1'b1;
    push.count   = step ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
    push.first   = a_valid ? res_a : res_b;
    push.second  = res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      line_count   <= LINE_W'(1);
      byte_offset  <= '0;
      token_begin  <= '0;
      ident_len    <= '0;
      number_accum <= '0;
      halted       <= 1'b0;
    end else if (step) begin
      mode        <= mode_next;
      line_count  <= line_next;
      halted      <= halt_set;
      byte_offset <= (cur < OFFSET_MAX) ? cur + OFFSET_WIDTH'(1) : cur;
      if (use_bt) begin
        token_begin <= cur;
      end
      if (use_bt && bt_ident) begin
        ident_len <= LW'(1);
      end else if (append) begin
        ident_len <= ident_len + LW'(1);
      end
      if (accum_load) begin
        number_accum <= NUMBER_WIDTH'(c == CH_ONE);
      end else if (accum_shift) begin
        number_accum <= {number_accum[NUMBER_WIDTH-2:0], c == CH_ONE};
      end
    end
  end

  // keep only the leading characters that a reserved word can span
  always_ff @(posedge clk) begin
    if (step) begin
      if (use_bt && bt_ident) begin
        ident_chars[0] <= c;
      end else if (append && len32 < 32'(KW_CHARS)) begin
        ident_chars[len32[2:0]] <= c;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lexkw_res_fifo.sv =====
// Result queue: takes up to two result words per cycle, gives one per cycle while head_ready is high.
// Depends on lexkw_pkg for the result word layout and depth.
`timescale 1ns / 1ps
`default_nettype none

module lexkw_res_fifo (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lexkw_pkg::push_t          push,
  output logic                           room,
  output lexkw_pkg::res_t                head,
  output logic                           head_valid,
  input  wire logic                      head_ready,
  output logic [lexkw_pkg::RES_CW-1:0]   level
);
  import lexkw_pkg::*;

  res_t              entries [RES_DEPTH];
  logic [RES_PW-1:0] wptr;
  logic [RES_PW-1:0] rptr;
  logic              pop;

  assign head_valid = (level != '0);
  assign pop        = head_valid && head_ready;
  assign room       = level <= RES_CW'(RES_DEPTH - 2);
  assign head       = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr + RES_PW'(push.count);
      rptr  <= rptr + RES_PW'(pop);
      level <= level + RES_CW'(push.count) - RES_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wptr + RES_PW'(1)] <= push.second;
    end
  end

endmodule

`default_nettype wire

// ===== verif/lexer_token_checker.sv =====
// Token checker for the keyword lexer: follows every accepted source byte, predicts the
// token words it causes and compares each output word, in order, field by field.
// Depends on lexkw_pkg for the character codes.
`timescale 1ns / 1ps

module lexer_token_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code
  input  logic        s_tuser,   // start_of_source
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,   // line_number, number_value, token_start, token_length
  input  logic [4:0]  m_tuser,   // token_kind
  input  logic        m_tlast,   // last_in_run
  output int          mismatch_count,
  output int          tokens_due
);
  import lexkw_pkg::*;

  typedef enum logic [4:0] {
    TK_ERROR, TK_IDENT, TK_NUMBER, TK_COMMENT,
    TK_AND, TK_BEGIN, TK_BOOLEAN, TK_ELIF, TK_ELSE, TK_END_WORD, TK_FALSE, TK_FOR,
    TK_IF, TK_INTEGER, TK_NOT, TK_OF, TK_OR, TK_PROGRAM, TK_READ, TK_SET, TK_TO,
    TK_TRUE, TK_WRITE, TK_EOS
  } token_kind_e;

  typedef enum logic [3:0] {
    SC_IDLE, SC_IDENT, SC_ZERO, SC_PREFIX, SC_DIGITS, SC_HASH, SC_BRACE, SC_BLOCK, SC_DASH
  } scan_mode_e;

  localparam logic [15:0] LINE_TOP  = 16'hFFFF;
  localparam logic [23:0] FIELD_TOP = 24'hFFFFFF;
  localparam int          IDENT_MAX = 15;
  localparam int          PRINT_MAX = 40;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [31:0] value;
    logic [23:0] start;
    logic [23:0] length;
    logic        last;
  } token_t;

  token_t       token_q[$];
  scan_mode_e   mode;
  logic [15:0]  line_cnt;
  logic [23:0]  offset;
  logic [23:0]  tok_begin;
  logic [119:0] ident_text;
  logic [4:0]   ident_len;
  logic [31:0]  accum;
  logic         halted;
  int           words_seen;

  initial begin
    mismatch_count = 0;
    tokens_due     = 0;
    words_seen     = 0;
  end

  function automatic token_kind_e word_kind(input logic [119:0] text);
    case (text)
      120'("and"):     return TK_AND;
      120'("begin"):   return TK_BEGIN;
      120'("boolean"): return TK_BOOLEAN;
      120'("elif"):    return TK_ELIF;
      120'("else"):    return TK_ELSE;
      120'("end"):     return TK_END_WORD;
      120'("false"):   return TK_FALSE;
      120'("for"):     return TK_FOR;
      120'("if"):      return TK_IF;
      120'("integer"): return TK_INTEGER;
      120'("not"):     return TK_NOT;
      120'("of"):      return TK_OF;
      120'("or"):      return TK_OR;
      120'("program"): return TK_PROGRAM;
      120'("read"):    return TK_READ;
      120'("set"):     return TK_SET;
      120'("to"):      return TK_TO;
      120'("true"):    return TK_TRUE;
      120'("write"):   return TK_WRITE;
      default:         return TK_IDENT;
    endcase
  endfunction

  task automatic clear_scanner();
    mode       = SC_IDLE;
    line_cnt   = 16'd1;
    offset     = '0;
    tok_begin  = '0;
    ident_text = '0;
    ident_len  = '0;
    accum      = '0;
    halted     = 1'b0;
  endtask

  task automatic bump_line();
    if (line_cnt != LINE_TOP) line_cnt++;
  endtask

  task automatic add_token(input token_kind_e kind, input logic [23:0] first,
                           input logic [24:0] stop, input logic [31:0] value);
    token_t      t;
    logic [24:0] span;
    span     = stop - {1'b0, first};
    t.kind   = kind;
    t.line   = line_cnt;
    t.value  = value;
    t.start  = first;
    t.length = (span > {1'b0, FIELD_TOP}) ? FIELD_TOP : span[23:0];
    t.last   = 1'b0;
    token_q.push_back(t);
  endtask

  task automatic raise_error(input logic [23:0] cur);
    add_token(TK_ERROR, tok_begin, {1'b0, cur}, '0);
    halted = 1'b1;
    mode   = SC_IDLE;
  endtask

  task automatic close_source(input logic [23:0] cur);
    add_token(TK_EOS, cur, {1'b0, cur}, '0);
    halted = 1'b1;
    mode   = SC_IDLE;
  endtask

  task automatic open_token(input logic [7:0] c, input logic [23:0] cur);
    tok_begin = cur;
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
    end else if (c == CH_LF) begin
      bump_line();
    end else if (c >= CH_LA && c <= CH_LZ) begin
      ident_text = {112'b0, c};
      ident_len  = 5'd1;
      mode       = SC_IDENT;
    end else if (c == CH_HASH) begin
      mode = SC_HASH;
    end else if (c == CH_LBRACE) begin
      mode = SC_BRACE;
    end else if (c == CH_ZERO) begin
      mode = SC_ZERO;
    end else if (c == CH_NUL) begin
      close_source(cur);
    end else begin
      raise_error(cur);
    end
  endtask

  task automatic scan_byte(input logic sos, input logic [7:0] c);
    int          q_size_in;
    logic [23:0] cur;
    logic        is_bin;
    token_t      t;
    if (sos) clear_scanner();
    if (!halted) begin
      q_size_in = token_q.size();
      cur       = offset;
      is_bin    = (c == CH_ZERO || c == CH_ONE);
      case (mode)
        SC_IDENT: begin
          if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_ZERO && c <= CH_NINE) || c == CH_UNDER) begin
            if (ident_len >= IDENT_MAX) begin
              raise_error(cur);
            end else begin
              ident_text = {ident_text[111:0], c};
              ident_len++;
            end
          end else if (c >= CH_UA && c <= CH_UZ) begin
            raise_error(cur);
          end else begin
            add_token(word_kind(ident_text), tok_begin, {1'b0, cur}, '0);
            mode = SC_IDLE;
            open_token(c, cur);
          end
        end
        SC_ZERO: begin
          if (c == CH_LB) mode = SC_PREFIX;
          else raise_error(cur);
        end
        SC_PREFIX: begin
          if (is_bin) begin
            accum = {31'b0, c[0]};
            mode  = SC_DIGITS;
          end else begin
            raise_error(cur);
          end
        end
        SC_DIGITS: begin
          if (is_bin) begin
            accum = {accum[30:0], c[0]};
          end else begin
            add_token(TK_NUMBER, tok_begin, {1'b0, cur}, accum);
            mode = SC_IDLE;
            open_token(c, cur);
          end
        end
        SC_HASH: begin
          if (c == CH_LF) begin
            bump_line();
            add_token(TK_COMMENT, tok_begin, {1'b0, cur} + 25'd1, '0);
            mode = SC_IDLE;
          end else if (c == CH_NUL) begin
            add_token(TK_COMMENT, tok_begin, {1'b0, cur}, '0);
            close_source(cur);
          end
        end
        SC_BRACE: begin
          if (c == CH_DASH) mode = SC_BLOCK;
          else raise_error(cur);
        end
        SC_BLOCK, SC_DASH: begin
          if (c == CH_NUL) begin
            add_token(TK_COMMENT, tok_begin, {1'b0, cur}, '0);
            close_source(cur);
          end else if (c == CH_RBRACE && mode == SC_DASH) begin
            add_token(TK_COMMENT, tok_begin, {1'b0, cur} + 25'd1, '0);
            mode = SC_IDLE;
          end else if (c == CH_DASH) begin
            mode = SC_DASH;
          end else begin
            if (c == CH_LF) bump_line();
            mode = SC_BLOCK;
          end
        end
        default: begin
          mode = SC_IDLE;
          open_token(c, cur);
        end
      endcase
      if (offset != FIELD_TOP) offset++;
      if (token_q.size() > q_size_in) begin
        t      = token_q.pop_back();
        t.last = 1'b1;
        token_q.push_back(t);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_MAX)
      $display("%0t: token word %0d %s mismatch: got 0x%0h, want 0x%0h",
               $time, words_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_token();
    token_t want;
    if (token_q.size() == 0) begin
      report_mismatch("unexpected word, kind", 32'(m_tuser), '0);
    end else begin
      want = token_q.pop_front();
      if (m_tuser != want.kind) report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
      if (m_tdata[15:0] != want.line)
        report_mismatch("line", 32'(m_tdata[15:0]), 32'(want.line));
      if (m_tdata[47:16] != want.value) report_mismatch("value", m_tdata[47:16], want.value);
      if (m_tdata[71:48] != want.start)
        report_mismatch("start", 32'(m_tdata[71:48]), 32'(want.start));
      if (m_tdata[95:72] != want.length)
        report_mismatch("length", 32'(m_tdata[95:72]), 32'(want.length));
      if (m_tlast != want.last) report_mismatch("last", 32'(m_tlast), 32'(want.last));
    end
    words_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scanner();
    end else begin
      if (m_tvalid && m_tready) check_token();
      if (s_tvalid && s_tready) scan_byte(s_tuser, s_tdata);
    end
    tokens_due <= token_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the keyword lexer testbench: clock, reset, source byte stimulus with random gaps,
// random output back-pressure, idle watchdog and verdict. Depends on lexkw_pkg,
// keyword_lexer_byte_stream_top and lexer_token_checker.
`timescale 1ns / 1ps

module tb_top;
  import lexkw_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int STIM_BYTES = 880;

  typedef struct packed {
    logic       sos;
    logic [7:0] ch;
  } src_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;
  int          mismatch_count;
  int          tokens_due;
  int          idle_cycles = 0;
  int          calm_left = 0;
  int          ready_hold = 0;
  int          ready_pick;
  int          sent_bytes = 0;
  logic        restart_next = 1'b0;
  src_byte_t   src_q[$];

  initial begin
    forever #1 clk = ~clk;
  end

  keyword_lexer_byte_stream_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  lexer_token_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .tokens_due     (tokens_due)
  );

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 4) begin
        m_tready <= 1'b1;
        ready_hold = $urandom_range(50, 150);
      end else if (ready_pick < 60) begin
        m_tready <= 1'b1;
        ready_hold = $urandom_range(0, 7);
      end else if (ready_pick < 94) begin
        m_tready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        m_tready <= 1'b0;
        ready_hold = $urandom_range(9, 39);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(0, 37);
    if (r < 26) return 8'(CH_LA + r);
    if (r < 36) return 8'(CH_ZERO + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return CH_TAB;
      1:       return CH_CR;
      2:       return CH_LF;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] comment_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    return (c == CH_LF) ? CH_SPACE : c;
  endfunction

  function automatic string keyword_text(input int idx);
    case (idx)
      0:       return "and";
      1:       return "begin";
      2:       return "boolean";
      3:       return "elif";
      4:       return "else";
      5:       return "end";
      6:       return "false";
      7:       return "for";
      8:       return "if";
      9:       return "integer";
      10:      return "not";
      11:      return "of";
      12:      return "or";
      13:      return "program";
      14:      return "read";
      15:      return "set";
      16:      return "to";
      17:      return "true";
      default: return "write";
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] ch);
    src_q.push_back({restart_next, ch});
    restart_next = 1'b0;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic gen_source();
    int pick;
    int len;
    restart_next = 1'b1;
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        put_text(keyword_text($urandom_range(0, 18)));
      end else if (pick < 45) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 15) : $urandom_range(0, 7);
        put_byte(8'(CH_LA + $urandom_range(0, 25)));
        repeat (len) put_byte(ident_char());
      end else if (pick < 62) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        put_text("0b");
        repeat (len) put_byte(($urandom_range(0, 1) != 0) ? CH_ONE : CH_ZERO);
      end else if (pick < 74) begin
        put_byte(CH_HASH);
        repeat ($urandom_range(0, 10)) put_byte(comment_char());
        if ($urandom_range(0, 9) != 0) put_byte(CH_LF);
      end else if (pick < 88) begin
        put_text("{-");
        repeat ($urandom_range(0, 12)) begin
          case ($urandom_range(0, 4))
            0:       put_byte(CH_DASH);
            1:       put_byte(CH_RBRACE);
            2:       put_byte(CH_LF);
            default: put_byte(comment_char());
          endcase
        end
        if ($urandom_range(0, 9) != 0) put_text("-}");
      end else if (pick < 95) begin
        case ($urandom_range(0, 3))
          0: begin
            put_byte(CH_LBRACE);
            put_byte(ident_char());
          end
          1: begin
            put_byte(CH_ZERO);
            put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
          end
          2: begin
            put_text("0b");
            put_byte(blank_char());
          end
          default: begin
            put_byte(8'(CH_LA + $urandom_range(0, 25)));
            put_byte(8'(CH_UA + $urandom_range(0, 25)));
          end
        endcase
      end else begin
        put_byte(8'($urandom_range(1, 255)));
      end
      repeat (($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 2)) put_byte(blank_char());
    end
    if ($urandom_range(0, 6) != 0) begin
      put_byte(CH_NUL);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_byte(input src_byte_t b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= b.sos;
    s_tdata  <= b.ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic wait_for_tokens();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tokens_due != 0) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    restart_next = 1'b1;
    put_byte(8'hFF);
    put_byte(CH_NUL);
    restart_next = 1'b1;
    put_text("if#x\n0b1");
    put_byte(CH_NUL);
    restart_next = 1'b1;
    put_text("{-a--}{x");
    restart_next = 1'b1;
    put_text("{-");
    put_byte(CH_NUL);
    while (src_q.size() > 0) send_byte(src_q.pop_front());
    wait_for_tokens();

    for (int n = 1; sent_bytes < STIM_BYTES; n++) begin
      gen_source();
      while (src_q.size() > 0) send_byte(src_q.pop_front());
      if (n % 9 == 0) wait_for_tokens();
    end

    wait_for_tokens();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && tokens_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lexkw_pkg.sv
rtl/lexkw_scan.sv
rtl/lexkw_res_fifo.sv
rtl/keyword_lexer_byte_stream_top.sv
verif/lexer_token_checker.sv
verif/tb_top.sv
